// ===== sv/lpc_pkg.sv =====
// shared types and constants for the line pattern classifier
// no dependencies; every other file refers to it by scoped names
package lpc_pkg;

  localparam int unsigned READING_W = 8;
  localparam int unsigned CFG_W     = 4;

  localparam logic [READING_W-1:0] MASK_SINGLE = 8'h7e;

  localparam logic [CFG_W-1:0] RST_SINGLE_WIDTH_MAX = 4'd4;
  localparam logic [CFG_W-1:0] RST_BRANCH_COUNT_MIN = 4'd3;
  localparam logic [CFG_W-1:0] RST_BRANCH_COUNT_MAX = 4'd6;
  localparam logic [CFG_W-1:0] RST_SOLID_COUNT_MIN  = 4'd6;

  typedef enum logic [1:0] {
    CFG_SINGLE_WIDTH_MAX = 2'd0,
    CFG_BRANCH_COUNT_MIN = 2'd1,
    CFG_BRANCH_COUNT_MAX = 2'd2,
    CFG_SOLID_COUNT_MIN  = 2'd3
  } cfg_index_t;

  typedef enum logic [3:0] {
    V_NONE           = 4'd0,
    V_STOP           = 4'd1,
    V_STRAIGHT       = 4'd2,
    V_LEFT           = 4'd3,
    V_RIGHT          = 4'd4,
    V_STRAIGHT_LEFT  = 4'd5,
    V_STRAIGHT_RIGHT = 4'd6,
    V_LEFT_RIGHT     = 4'd7,
    V_ALL            = 4'd8,
    V_ERROR          = 4'd9
  } verdict_t;

  typedef struct packed {
    logic [READING_W-1:0] first_reading;
    logic [READING_W-1:0] second_reading;
  } in_word_t;

  typedef struct packed {
    verdict_t verdict;
    logic     probe_used;
  } out_word_t;

  typedef struct packed {
    logic [CFG_W-1:0] single_width_max;
    logic [CFG_W-1:0] branch_count_min;
    logic [CFG_W-1:0] branch_count_max;
    logic [CFG_W-1:0] solid_count_min;
  } cfg_t;

endpackage

// ===== sv/lpc_cfg.sv =====
// configuration register file of the line pattern classifier
// depends on lpc_pkg
module lpc_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  lpc_pkg::cfg_index_t          cfg_index,
  input  logic [lpc_pkg::CFG_W-1:0]    cfg_data,
  output lpc_pkg::cfg_t                cfg
);

  lpc_pkg::cfg_t cfg_reg;
  lpc_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg_reg;
    if (cfg_write) begin
      unique case (cfg_index)
        lpc_pkg::CFG_SINGLE_WIDTH_MAX: cfg_next.single_width_max = cfg_data;
        lpc_pkg::CFG_BRANCH_COUNT_MIN: cfg_next.branch_count_min = cfg_data;
        lpc_pkg::CFG_BRANCH_COUNT_MAX: cfg_next.branch_count_max = cfg_data;
        lpc_pkg::CFG_SOLID_COUNT_MIN:  cfg_next.solid_count_min  = cfg_data;
        default:                       cfg_next = cfg_reg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg.single_width_max <= lpc_pkg::RST_SINGLE_WIDTH_MAX;
      cfg_reg.branch_count_min <= lpc_pkg::RST_BRANCH_COUNT_MIN;
      cfg_reg.branch_count_max <= lpc_pkg::RST_BRANCH_COUNT_MAX;
      cfg_reg.solid_count_min  <= lpc_pkg::RST_SOLID_COUNT_MIN;
    end else begin
      cfg_reg <= cfg_next;
    end
  end

  assign cfg = cfg_reg;

endmodule

// ===== sv/lpc_classify.sv =====
// combinational run checks and verdict selection for one word
// depends on lpc_pkg
module lpc_classify (
  input  lpc_pkg::in_word_t  in_word,
  input  lpc_pkg::cfg_t      cfg,
  output lpc_pkg::out_word_t out_word
);

  function automatic logic [3:0] popcount8(input logic [7:0] d);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, d[i]};
    end
    return n;
  endfunction

  // zeros below the lowest black bit, 8 when blank
  function automatic logic [3:0] low_zeros8(input logic [7:0] d);
    logic [3:0] n;
    n = 4'd8;
    for (int i = 7; i >= 0; i--) begin
      if (d[i]) begin
        n = 4'(i);
      end
    end
    return n;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] d);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = d[7-i];
    end
    return r;
  endfunction

  function automatic logic [3:0] stop_limit(input logic [2:0] ph);
    logic [3:0] lim;
    unique case (ph)
      3'd0:    lim = 4'd2;
      3'd1:    lim = 4'd4;
      3'd2:    lim = 4'd6;
      3'd3:    lim = 4'd6;
      default: lim = 4'd8;
    endcase
    return lim;
  endfunction

  // runs from bit 0: zeros, black, white, black, white, black, zeros
  function automatic logic stop_mark(input logic [7:0] d);
    logic [2:0] ph;
    logic [6:0] seen;
    logic       bad;
    logic       done;
    logic [3:0] pos;
    ph   = '0;
    seen = '0;
    bad  = 1'b0;
    for (int i = 0; i < 8; i++) begin
      done = 1'b0;
      pos  = 4'(i);
      for (int k = 0; k < 7; k++) begin
        if (!done) begin
          if (ph == 3'd6) begin
            done = 1'b1;
            if (d[i]) begin
              bad = 1'b1;
            end
          end else if (pos < stop_limit(ph) && d[i] == ph[0]) begin
            done     = 1'b1;
            seen[ph] = 1'b1;
          end else begin
            ph = ph + 3'd1;
          end
        end
      end
    end
    return !bad && (&seen[5:1]);
  endfunction

  // one contiguous run inside the outer sensors
  function automatic logic single_line(input logic [7:0] d, input logic [3:0] wmax);
    logic [7:0] m;
    logic [3:0] edges;
    m     = d & lpc_pkg::MASK_SINGLE;
    edges = '0;
    for (int i = 0; i < 7; i++) begin
      edges = edges + {3'd0, m[i] ^ m[i+1]};
    end
    return (edges == 4'd2) && (popcount8(m) <= wmax);
  endfunction

  // white first, then black with at most one white gap up to the far end
  function automatic logic branch_scan(input logic [7:0] d, input logic [3:0] cmin,
                                       input logic [3:0] cmax);
    logic [3:0] n;
    logic [3:0] tz;
    logic [4:0] span;
    n    = popcount8(d);
    tz   = low_zeros8(d);
    span = {1'b0, n} + {1'b0, tz};
    return (tz != 4'd0) && (tz != 4'd8) && (span >= 5'd7) && (n >= cmin) && (n <= cmax);
  endfunction

  logic [7:0] a;
  logic [7:0] b;
  logic       a_stop;
  logic       a_line;
  logic       b_stop;
  logic       b_line;
  logic       a_left;
  logic       a_right;
  logic       a_solid;

  assign a       = in_word.first_reading;
  assign b       = in_word.second_reading;
  assign a_stop  = stop_mark(a);
  assign b_stop  = stop_mark(b);
  assign a_line  = single_line(a, cfg.single_width_max);
  assign b_line  = single_line(b, cfg.single_width_max);
  assign a_left  = branch_scan(a, cfg.branch_count_min, cfg.branch_count_max);
  assign a_right = branch_scan(reverse8(a), cfg.branch_count_min, cfg.branch_count_max);
  assign a_solid = popcount8(a) >= cfg.solid_count_min;

  always_comb begin
    out_word.probe_used = 1'b1;
    priority if (a == 8'd0) begin
      out_word.verdict    = lpc_pkg::V_NONE;
      out_word.probe_used = 1'b0;
    end else if (a_stop) begin
      out_word.verdict    = lpc_pkg::V_STOP;
      out_word.probe_used = 1'b0;
    end else if (a_line) begin
      out_word.verdict    = lpc_pkg::V_STRAIGHT;
      out_word.probe_used = 1'b0;
    end else if (a_left) begin
      out_word.verdict = b_line ? lpc_pkg::V_STRAIGHT_LEFT : lpc_pkg::V_LEFT;
    end else if (a_right) begin
      out_word.verdict = b_line ? lpc_pkg::V_STRAIGHT_RIGHT : lpc_pkg::V_RIGHT;
    end else if (a_solid) begin
      out_word.verdict = b_line ? lpc_pkg::V_ALL : lpc_pkg::V_LEFT_RIGHT;
    end else if (b == 8'd0) begin
      out_word.verdict = lpc_pkg::V_NONE;
    end else if (b_stop) begin
      out_word.verdict = lpc_pkg::V_STOP;
    end else if (b_line) begin
      out_word.verdict = lpc_pkg::V_STRAIGHT;
    end else begin
      out_word.verdict = lpc_pkg::V_ERROR;
    end
  end

endmodule

// ===== sv/line_pattern_classifier.sv =====
// Line pattern classifier: turns a pair of 8-bit sensor words into a track verdict.
// A word is taken into an input register, classified combinationally by lpc_classify and held
// in an output register until taken; one word per cycle is sustained while out_ready is high.
// The result moves from the input register to the output register. A result left waiting
// holds the input register and drops in_ready once that register is full. The user must
// write the four 4-bit thresholds through the cfg port while idle; the block does not check.
// depends on lpc_pkg, lpc_cfg, lpc_classify
module line_pattern_classifier (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lpc_pkg::in_word_t             in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output lpc_pkg::out_word_t            out_word,
  input  logic                          cfg_write,
  input  lpc_pkg::cfg_index_t           cfg_index,
  input  logic [lpc_pkg::CFG_W-1:0]     cfg_data
);

  lpc_pkg::cfg_t      cfg;
  lpc_pkg::in_word_t  s1_word;
  logic               s1_valid;
  lpc_pkg::out_word_t s1_result;
  lpc_pkg::out_word_t out_reg;
  logic               out_free;
  logic               s1_advance;

  lpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lpc_classify u_classify (
    .in_word  (s1_word),
    .cfg      (cfg),
    .out_word (s1_result)
  );

  assign out_free   = !out_valid || out_ready;
  assign s1_advance = s1_valid && out_free;
  assign in_ready   = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_word <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_reg <= s1_result;
    end
  end

  assign out_word = out_reg;

`ifndef NO_ASSERTIONS
  a_reset_empties: assert property (@(posedge clk) rst |=> !s1_valid && !out_valid)
    else $error("pipeline not empty after reset");

  a_s1_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_word))
    else $error("stalled word lost from input register");

  a_no_probe_early: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.probe_used |->
      out_word.verdict == lpc_pkg::V_NONE || out_word.verdict == lpc_pkg::V_STOP ||
      out_word.verdict == lpc_pkg::V_STRAIGHT)
    else $error("late verdict without second reading");

  a_probe_combo: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_word.verdict == lpc_pkg::V_LEFT ||
      out_word.verdict == lpc_pkg::V_RIGHT || out_word.verdict == lpc_pkg::V_STRAIGHT_LEFT ||
      out_word.verdict == lpc_pkg::V_STRAIGHT_RIGHT ||
      out_word.verdict == lpc_pkg::V_LEFT_RIGHT || out_word.verdict == lpc_pkg::V_ALL ||
      out_word.verdict == lpc_pkg::V_ERROR) |-> out_word.probe_used)
    else $error("branch verdict without probe flag");
`endif

endmodule
